// ===== design/rrts_pkg.sv =====
// rrts_pkg: shared types and constants for the round-robin task ring scheduler
// no dependencies; used by round_robin_task_ring_scheduler
`default_nettype none

package rrts_pkg;

    typedef enum logic [1:0] {
        MODE_ACTIVATE = 2'd0,
        MODE_YIELD    = 2'd1,
        MODE_DONE     = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    localparam int TASK_ID_W   = 4;
    localparam int ADDR_FIELD_W = 32;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 40;

endpackage

`default_nettype wire

// ===== design/rrts_addr_store.sv =====
// rrts_addr_store: saved task address memory, one write and one registered read port
// entries read as zero until first written; uses no package
`default_nettype none

module rrts_addr_store #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_idx,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [IW-1:0] rd_idx,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    q_reg;
    logic             qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        q_reg  <= mem[rd_idx];
        qv_reg <= vld_reg[rd_idx];
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

`default_nettype wire

// ===== design/round_robin_task_ring_scheduler.sv =====
// round_robin_task_ring_scheduler: cooperative round-robin scheduler over a task ring
// uses rrts_pkg and rrts_addr_store
// activate: accept, then fetch and result states; a new task is first spliced in via link_new and link_cur
// yield and done: a ring walk to the next ready task (up to MAX_TASKS hops), then fetch and result
// one request at a time; the ring pointer memory read port sets the walk at one hop a cycle
// reset: running task 0, only task 0 ready and linked, takes effect at once, no clearing pass
`default_nettype none

module round_robin_task_ring_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // task_id[3:0], entry_addr[35:4], resume_addr[67:36], zero fill
    input  wire logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // current_task[3:0], run_addr[35:4], zero fill
    output logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[0]
    output logic [0:0]                         m_tuser
);

    localparam int TW  = $clog2(MAX_TASKS);
    localparam int SW  = $clog2(MAX_TASKS + 1);
    localparam int SAW = (ADDR_WIDTH < rrts_pkg::ADDR_FIELD_W) ? ADDR_WIDTH
                                                               : rrts_pkg::ADDR_FIELD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINK_NEW,
        ST_LINK_CUR,
        ST_WALK,
        ST_FETCH,
        ST_RESULT
    } state_t;

    state_t                        state_reg;
    rrts_pkg::mode_t               mode_reg;
    logic [TW-1:0]                 cur_reg;
    logic [TW-1:0]                 tid_reg;
    logic                          status_reg;
    logic [SW-1:0]                 steps_reg;
    logic [MAX_TASKS-1:0]          ready_reg;
    logic [MAX_TASKS-1:0]          linked_reg;
    logic [MAX_TASKS-1:0]          ring_vld_reg;
    logic                          m_tvalid_reg;
    logic [rrts_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    logic [TW-1:0]                 ring_mem [MAX_TASKS];
    logic [TW-1:0]                 ring_q_reg;
    logic                          ring_qv_reg;

    rrts_pkg::mode_t               in_mode;
    logic [rrts_pkg::TASK_ID_W-1:0] in_tid;
    logic [SAW-1:0]                in_entry;
    logic [SAW-1:0]                in_resume;
    logic                          s_accept;
    logic                          act_ok;
    logic [TW-1:0]                 tid_idx;
    logic [TW-1:0]                 walk_t;
    logic                          walk_go;
    logic [TW-1:0]                 ring_raddr;
    logic                          ring_we;
    logic [TW-1:0]                 ring_waddr;
    logic [TW-1:0]                 ring_wdata;
    logic                          addr_we;
    logic [TW-1:0]                 addr_widx;
    logic [SAW-1:0]                addr_wdata;
    logic [SAW-1:0]                addr_rd;

    assign in_mode   = rrts_pkg::mode_t'(s_tuser);
    assign in_tid    = s_tdata[3:0];
    assign in_entry  = s_tdata[4 +: SAW];
    assign in_resume = s_tdata[36 +: SAW];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign act_ok   = (32'(in_tid) < 32'(MAX_TASKS)) && (in_entry != '0);
    assign tid_idx  = TW'(in_tid);

    // ring successor as read last cycle; never-written entries read as task 0
    assign walk_t     = ring_qv_reg ? ring_q_reg : '0;
    assign walk_go    = (steps_reg < SW'(MAX_TASKS)) && (walk_t != cur_reg);
    assign ring_raddr = (state_reg == ST_WALK) ? walk_t : cur_reg;

    always_comb
    begin
        ring_we    = 1'b0;
        ring_waddr = cur_reg;
        ring_wdata = tid_reg;
        if (state_reg == ST_LINK_NEW)
        begin
            ring_we    = 1'b1;
            ring_waddr = tid_reg;
            ring_wdata = walk_t;
        end
        else if (state_reg == ST_LINK_CUR)
        begin
            ring_we = 1'b1;
        end
    end

    always_comb
    begin
        addr_we    = 1'b0;
        addr_widx  = cur_reg;
        addr_wdata = in_resume;
        if (s_accept && in_mode == rrts_pkg::MODE_ACTIVATE && act_ok)
        begin
            addr_we    = 1'b1;
            addr_widx  = tid_idx;
            addr_wdata = in_entry;
        end
        else if (s_accept && in_mode == rrts_pkg::MODE_YIELD)
        begin
            addr_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
        end
        else if (ring_we)
        begin
            ring_vld_reg[ring_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q_reg  <= ring_mem[ring_raddr];
        ring_qv_reg <= ring_vld_reg[ring_raddr];
    end

    rrts_addr_store #(
        .DEPTH (MAX_TASKS),
        .IW    (TW),
        .DW    (SAW)
    ) u_addr_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (addr_we),
        .wr_idx  (addr_widx),
        .wr_data (addr_wdata),
        .rd_idx  (cur_reg),
        .rd_data (addr_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= rrts_pkg::MODE_NONE;
            cur_reg      <= '0;
            tid_reg      <= '0;
            status_reg   <= rrts_pkg::STATUS_OK;
            steps_reg    <= '0;
            ready_reg    <= MAX_TASKS'(1);
            linked_reg   <= MAX_TASKS'(1);
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != ST_RESULT)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        mode_reg   <= in_mode;
                        tid_reg    <= tid_idx;
                        steps_reg  <= '0;
                        status_reg <= rrts_pkg::STATUS_OK;
                        unique case (in_mode)
                            rrts_pkg::MODE_ACTIVATE:
                            begin
                                if (!act_ok)
                                begin
                                    status_reg <= rrts_pkg::STATUS_REJECT;
                                    state_reg  <= ST_FETCH;
                                end
                                else
                                begin
                                    ready_reg[tid_idx] <= 1'b1;
                                    state_reg <= linked_reg[tid_idx] ? ST_FETCH : ST_LINK_NEW;
                                end
                            end
                            rrts_pkg::MODE_YIELD:
                            begin
                                state_reg <= ST_WALK;
                            end
                            rrts_pkg::MODE_DONE:
                            begin
                                ready_reg[cur_reg] <= 1'b0;
                                state_reg          <= ST_WALK;
                            end
                            rrts_pkg::MODE_NONE:
                            begin
                                state_reg <= ST_FETCH;
                            end
                        endcase
                    end
                end
                ST_LINK_NEW:
                begin
                    linked_reg[tid_reg] <= 1'b1;
                    state_reg           <= ST_LINK_CUR;
                end
                ST_LINK_CUR:
                begin
                    state_reg <= ST_FETCH;
                end
                ST_WALK:
                begin
                    priority if (walk_go && ready_reg[walk_t])
                    begin
                        cur_reg   <= walk_t;
                        state_reg <= ST_FETCH;
                    end
                    else if (walk_go)
                    begin
                        steps_reg <= steps_reg + SW'(1);
                    end
                    else
                    begin
                        // nothing else ready: keep running task, or fall back to main
                        if (!ready_reg[cur_reg] && mode_reg == rrts_pkg::MODE_DONE)
                        begin
                            cur_reg      <= '0;
                            ready_reg[0] <= 1'b1;
                        end
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0000, rrts_pkg::ADDR_FIELD_W'(addr_rd),
                                         rrts_pkg::TASK_ID_W'(cur_reg)};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_cur_linked: assert property (@(posedge clk) disable iff (!rst_n)
        linked_reg[cur_reg])
        else $error("running task is not linked into the ring");

    a_idle_cur_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ready_reg[cur_reg])
        else $error("running task is not ready between requests");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (steps_reg < SW'(MAX_TASKS)))
        else $error("ring walk ran past the task count");

    a_main_linked: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != ST_IDLE) && linked_reg[0])
        else $error("accepted word did not start work or main task unlinked");

endmodule

`default_nettype wire
